/* hdl/cacru_pkg.sv */
package cacru_pkg;

  // field widths of the transfers
  localparam int WAVE_FIELD_W   = 8;
  localparam int GENOME_FIELD_W = 8;
  localparam int MASK_W         = 9;
  localparam int PACKED_W       = 64;
  localparam int WORD_W         = 32;

  // defaults for the top-level parameters
  localparam int WAVE_BITS_DEF   = 8;
  localparam int GENOME_BITS_DEF = 8;

  // neighbourhood layout: eight lanes, centre is cell 4
  localparam int NUM_LANES   = 8;
  localparam int CENTRE_CELL = 4;
  localparam int CNT_W       = 4;

  // reciprocal table for the mean, floor(sum * recip >> shift) == sum / n
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 17;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int RULE_W     = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_RULE = '0;

  typedef enum logic [RULE_W-1:0] {
    RULE_LIFE,
    RULE_DIFFUSE,
    RULE_GENOMIC,
    RULE_AND,
    RULE_OR,
    RULE_XOR,
    RULE_THR_AND,
    RULE_THR_OR
  } rule_t;

  typedef struct packed {
    logic [MASK_W-1:0]         alive_mask;
    logic [WAVE_FIELD_W-1:0]   center_wave;
    logic [PACKED_W-1:0]       neighbor_waves;
    logic [GENOME_FIELD_W-1:0] center_genome;
    logic [PACKED_W-1:0]       neighbor_genomes;
    logic [WORD_W-1:0]         center_link_genome;
    logic [WORD_W-1:0]         center_fitness;
  } in_item_t;

  typedef struct packed {
    logic                      next_alive;
    logic [WAVE_FIELD_W-1:0]   next_wave;
    logic [GENOME_FIELD_W-1:0] genome_out;
    logic [WORD_W-1:0]         link_genome_out;
    logic [WORD_W-1:0]         fitness_out;
  } out_item_t;

  // per-lane status
  typedef struct packed {
    logic alive;
    logic match;
  } lane_flag_t;

  // merged counts
  typedef struct packed {
    logic [CNT_W-1:0] alive_cnt;
    logic [CNT_W-1:0] match_cnt;
  } count_t;

  // centre fields carried along the pipeline unchanged
  typedef struct packed {
    logic [GENOME_FIELD_W-1:0] genome;
    logic [WORD_W-1:0]         link;
    logic [WORD_W-1:0]         fitness;
  } pass_t;

  // ceil(2^RECIP_SHIFT / n); zero for an empty neighbourhood
  function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    case (cnt)
      CNT_W'(1): r = RECIP_W'(65536);
      CNT_W'(2): r = RECIP_W'(32768);
      CNT_W'(3): r = RECIP_W'(21846);
      CNT_W'(4): r = RECIP_W'(16384);
      CNT_W'(5): r = RECIP_W'(13108);
      CNT_W'(6): r = RECIP_W'(10923);
      CNT_W'(7): r = RECIP_W'(9363);
      CNT_W'(8): r = RECIP_W'(8192);
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/cacru_lane.sv */
module cacru_lane #(
  parameter int WAVE_BITS   = cacru_pkg::WAVE_BITS_DEF,
  parameter int GENOME_BITS = cacru_pkg::GENOME_BITS_DEF
) (
  input  logic                   alive_i,
  input  logic [WAVE_BITS-1:0]   wave_i,
  input  logic [GENOME_BITS-1:0] genome_i,
  input  logic [GENOME_BITS-1:0] centre_genome_i,
  output cacru_pkg::lane_flag_t  flag_o,
  output logic [WAVE_BITS-1:0]   sum_wave_o,
  output logic [WAVE_BITS-1:0]   and_wave_o
);
  import cacru_pkg::*;

  // status of this neighbour
  always_comb begin
    flag_o.alive = alive_i;
    flag_o.match = (genome_i == centre_genome_i);
  end

  // dead neighbours give the identity of each reduction
  assign sum_wave_o = alive_i ? wave_i : '0;
  assign and_wave_o = alive_i ? wave_i : '1;

endmodule

/* hdl/cacru_merge.sv */
module cacru_merge #(
  parameter int WAVE_BITS = cacru_pkg::WAVE_BITS_DEF,
  localparam int SUM_W    = WAVE_BITS + $clog2(cacru_pkg::NUM_LANES)
) (
  input  logic                  clk,
  input  logic                  ld_i,
  input  cacru_pkg::lane_flag_t flag_i     [cacru_pkg::NUM_LANES],
  input  logic [WAVE_BITS-1:0]  sum_wave_i [cacru_pkg::NUM_LANES],
  input  logic [WAVE_BITS-1:0]  and_wave_i [cacru_pkg::NUM_LANES],
  input  logic [WAVE_BITS-1:0]  centre_wave_i,
  output cacru_pkg::count_t     cnt_o,
  output logic [SUM_W-1:0]      sum_o,
  output logic [WAVE_BITS-1:0]  and_o,
  output logic [WAVE_BITS-1:0]  or_o,
  output logic [WAVE_BITS-1:0]  xor_o
);
  import cacru_pkg::*;

  count_t              cnt_nxt;
  logic [SUM_W-1:0]     sum_nxt;
  logic [WAVE_BITS-1:0] and_nxt;
  logic [WAVE_BITS-1:0] or_nxt;
  logic [WAVE_BITS-1:0] xor_nxt;

  // combine the lane results: counts, wave sum and bitwise reductions
  always_comb begin
    cnt_nxt = '0;
    sum_nxt = '0;
    and_nxt = centre_wave_i;
    or_nxt  = centre_wave_i;
    xor_nxt = centre_wave_i;
    for (int k = 0; k < NUM_LANES; k++) begin
      cnt_nxt.alive_cnt = cnt_nxt.alive_cnt + CNT_W'(flag_i[k].alive);
      cnt_nxt.match_cnt = cnt_nxt.match_cnt + CNT_W'(flag_i[k].match);
      sum_nxt = sum_nxt + SUM_W'(sum_wave_i[k]);
      and_nxt = and_nxt & and_wave_i[k];
      or_nxt  = or_nxt | sum_wave_i[k];
      xor_nxt = xor_nxt ^ sum_wave_i[k];
    end
  end

  // merge stage register
  always_ff @(posedge clk) begin
    if (ld_i) begin
      cnt_o <= cnt_nxt;
      sum_o <= sum_nxt;
      and_o <= and_nxt;
      or_o  <= or_nxt;
      xor_o <= xor_nxt;
    end
  end

endmodule

/* hdl/cacru_rule.sv */
module cacru_rule #(
  parameter int WAVE_BITS = cacru_pkg::WAVE_BITS_DEF,
  localparam int SUM_W    = WAVE_BITS + $clog2(cacru_pkg::NUM_LANES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ld_i,
  input  cacru_pkg::rule_t     rule_i,
  input  cacru_pkg::count_t    cnt_i,
  input  logic [SUM_W-1:0]     sum_i,
  input  logic [WAVE_BITS-1:0] and_i,
  input  logic [WAVE_BITS-1:0] or_i,
  input  logic [WAVE_BITS-1:0] xor_i,
  input  logic                 centre_alive_i,
  input  logic [WAVE_BITS-1:0] centre_wave_i,
  output logic                 alive_o,
  output logic [WAVE_BITS-1:0] wave_o
);
  import cacru_pkg::*;

  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int WAVE_MAX = (1 << WAVE_BITS) - 1;
  localparam logic [WAVE_BITS-1:0] THR_HALF = WAVE_BITS'(WAVE_MAX >> 1);
  localparam logic [WAVE_BITS-1:0] THR_HIGH = WAVE_BITS'((WAVE_MAX * 3) >> 2);

  logic [PROD_W-1:0]    prod_nxt;
  logic [WAVE_BITS-1:0] avg_nxt;

  count_t               cnt_r;
  logic [WAVE_BITS-1:0] avg_r;
  logic [WAVE_BITS-1:0] and_r;
  logic [WAVE_BITS-1:0] or_r;
  logic [WAVE_BITS-1:0] xor_r;
  logic                 calive_r;
  logic [WAVE_BITS-1:0] cw_r;

  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] birth;
  logic             n_two_three;

  // mean of the alive neighbour waves by reciprocal multiply
  assign prod_nxt = PROD_W'(sum_i) * PROD_W'(recip_of(cnt_i.alive_cnt));
  assign avg_nxt  = prod_nxt[RECIP_SHIFT +: WAVE_BITS];

  // mean stage register
  always_ff @(posedge clk) begin
    if (ld_i) begin
      cnt_r    <= cnt_i;
      avg_r    <= avg_nxt;
      and_r    <= and_i;
      or_r     <= or_i;
      xor_r    <= xor_i;
      calive_r <= centre_alive_i;
      cw_r     <= centre_wave_i;
    end
  end

  assign n           = cnt_r.alive_cnt;
  assign n_two_three = n inside {CNT_W'(2), CNT_W'(3)};

  // birth count of genomic life from the genome match count
  always_comb begin
    if (cnt_r.match_cnt >= CNT_W'(7)) begin
      birth = CNT_W'(4);
    end else if (cnt_r.match_cnt <= CNT_W'(1)) begin
      birth = CNT_W'(2);
    end else begin
      birth = CNT_W'(3);
    end
  end

  // rule select
  always_comb begin
    alive_o = 1'b0;
    wave_o  = cw_r;
    case (rule_i)
      RULE_LIFE: begin
        alive_o = calive_r ? n_two_three : (n == CNT_W'(3));
      end
      RULE_DIFFUSE: begin
        alive_o = (n >= CNT_W'(2)) && (n <= CNT_W'(4));
        if (n != '0) begin
          wave_o = avg_r;
        end
      end
      RULE_GENOMIC: begin
        alive_o = calive_r ? n_two_three : (n == birth);
      end
      RULE_AND: begin
        alive_o = (n != '0);
        wave_o  = and_r;
      end
      RULE_OR: begin
        alive_o = (n != '0);
        wave_o  = or_r;
      end
      RULE_XOR: begin
        alive_o = (n != '0);
        wave_o  = xor_r;
      end
      RULE_THR_AND: begin
        alive_o = (n >= CNT_W'(2)) && (avg_r > THR_HALF);
        if (alive_o) begin
          wave_o = avg_r;
        end
      end
      RULE_THR_OR: begin
        alive_o = (n != '0) || (cw_r > THR_HIGH);
      end
      default: begin
        alive_o = 1'b0;
        wave_o  = cw_r;
      end
    endcase
  end

  // an empty neighbourhood only keeps a cell alive under threshold-or
  a_empty_dead: assert property (@(posedge clk) disable iff (!rst_n)
    ((n == '0) && (rule_i != RULE_THR_OR)) |-> !alive_o)
    else $error("cell alive with no alive neighbour");

  // diffuse without alive neighbours keeps the centre wave
  a_diffuse_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ((rule_i == RULE_DIFFUSE) && (n == '0)) |-> (wave_o == cw_r))
    else $error("diffuse changed wave of an isolated cell");

  // the mean never exceeds the largest wave
  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (n != '0) |-> (32'(avg_r) <= 32'(WAVE_MAX)))
    else $error("mean wave out of range");

endmodule

/* hdl/ca_cell_rule_update_core.sv */
// next-state unit for one cellular-automaton cell over its 3x3 neighbourhood
//
// input channel (in_valid / in_stall / in_data): one neighbourhood per transfer,
// alive mask, centre and neighbour waves and genomes, plus two pass-through words
// result channel (out_valid / out_stall / out_data): one result per input, in order
// configuration port (cfg_*): APB-style, rule_select at byte address 0, pready
// always high, reads return the current rule; change it only while the unit is idle
//
// latency: out_valid rises three cycles after the input transfer, so the earliest
// result transfer comes four clock edges after it
// throughput: one item per cycle through four register stages (lane flags, merge
// tree, reciprocal multiply for the mean, rule select into the output register)
// a held result stalls only the full stages behind it, empty stages still fill;
// in_stall rises only when all four stages are full and out_stall is high
// reset: all stages empty, out_valid low, rule_select back to life
module ca_cell_rule_update_core #(
  parameter int WAVE_BITS   = cacru_pkg::WAVE_BITS_DEF,
  parameter int GENOME_BITS = cacru_pkg::GENOME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  cacru_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output cacru_pkg::out_item_t                 out_data,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [cacru_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [cacru_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [cacru_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                 cfg_pready
);
  import cacru_pkg::*;

  localparam int SUM_W = WAVE_BITS + $clog2(NUM_LANES);

  // configuration
  rule_t rule_r;

  // pipeline control
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy0, rdy1, rdy2, rdy3;

  // lane outputs
  lane_flag_t           flag_c     [NUM_LANES];
  logic [WAVE_BITS-1:0] sum_wave_c [NUM_LANES];
  logic [WAVE_BITS-1:0] and_wave_c [NUM_LANES];

  // stage 1
  lane_flag_t           flag_s1_r     [NUM_LANES];
  logic [WAVE_BITS-1:0] sum_wave_s1_r [NUM_LANES];
  logic [WAVE_BITS-1:0] and_wave_s1_r [NUM_LANES];
  logic                 calive_s1_r;
  logic [WAVE_BITS-1:0] cw_s1_r;
  pass_t                pass_s1_r;

  // stage 2
  count_t               cnt_s2;
  logic [SUM_W-1:0]     sum_s2;
  logic [WAVE_BITS-1:0] and_s2;
  logic [WAVE_BITS-1:0] or_s2;
  logic [WAVE_BITS-1:0] xor_s2;
  logic                 calive_s2_r;
  logic [WAVE_BITS-1:0] cw_s2_r;
  pass_t                pass_s2_r;

  // stage 3
  pass_t                pass_s3_r;
  logic                 alive_s3;
  logic [WAVE_BITS-1:0] wave_s3;

  out_item_t out_data_r;
  pass_t     pass_in;

  logic [GENOME_BITS-1:0] centre_genome;
  logic                   cfg_wr;

  // configuration register write and read back
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_RULE) ? CFG_DATA_W'(rule_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r <= RULE_LIFE;
    end else if (cfg_wr && (cfg_paddr[CFG_ADDR_W-1:2] == REG_RULE)) begin
      rule_r <= rule_t'(cfg_pwdata[RULE_W-1:0]);
    end
  end

  // stage handshake, each stage moves when its successor frees up
  assign rdy3     = !out_valid_r || !out_stall;
  assign rdy2     = !v3_r || rdy3;
  assign rdy1     = !v2_r || rdy2;
  assign rdy0     = !v1_r || rdy1;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy0) begin
        v1_r <= in_valid;
      end
      if (rdy1) begin
        v2_r <= v1_r;
      end
      if (rdy2) begin
        v3_r <= v2_r;
      end
      if (rdy3) begin
        out_valid_r <= v3_r;
      end
    end
  end

  // one lane per neighbour
  assign centre_genome = in_data.center_genome[GENOME_BITS-1:0];

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    localparam int CELL = (k < CENTRE_CELL) ? k : k + 1;
    cacru_lane #(
      .WAVE_BITS   (WAVE_BITS),
      .GENOME_BITS (GENOME_BITS)
    ) u_lane (
      .alive_i         (in_data.alive_mask[CELL]),
      .wave_i          (in_data.neighbor_waves[8*k +: WAVE_BITS]),
      .genome_i        (in_data.neighbor_genomes[8*k +: GENOME_BITS]),
      .centre_genome_i (centre_genome),
      .flag_o          (flag_c[k]),
      .sum_wave_o      (sum_wave_c[k]),
      .and_wave_o      (and_wave_c[k])
    );
  end

  // fields that ride along unchanged
  always_comb begin
    pass_in.genome  = GENOME_FIELD_W'(centre_genome);
    pass_in.link    = in_data.center_link_genome;
    pass_in.fitness = in_data.center_fitness;
  end

  // lane stage register
  always_ff @(posedge clk) begin
    if (rdy0) begin
      flag_s1_r     <= flag_c;
      sum_wave_s1_r <= sum_wave_c;
      and_wave_s1_r <= and_wave_c;
      calive_s1_r   <= in_data.alive_mask[CENTRE_CELL];
      cw_s1_r       <= in_data.center_wave[WAVE_BITS-1:0];
      pass_s1_r     <= pass_in;
    end
  end

  cacru_merge #(
    .WAVE_BITS (WAVE_BITS)
  ) u_merge (
    .clk           (clk),
    .ld_i          (rdy1),
    .flag_i        (flag_s1_r),
    .sum_wave_i    (sum_wave_s1_r),
    .and_wave_i    (and_wave_s1_r),
    .centre_wave_i (cw_s1_r),
    .cnt_o         (cnt_s2),
    .sum_o         (sum_s2),
    .and_o         (and_s2),
    .or_o          (or_s2),
    .xor_o         (xor_s2)
  );

  // centre data alongside the merge stage
  always_ff @(posedge clk) begin
    if (rdy1) begin
      calive_s2_r <= calive_s1_r;
      cw_s2_r     <= cw_s1_r;
      pass_s2_r   <= pass_s1_r;
    end
  end

  cacru_rule #(
    .WAVE_BITS (WAVE_BITS)
  ) u_rule (
    .clk            (clk),
    .rst_n          (rst_n),
    .ld_i           (rdy2),
    .rule_i         (rule_r),
    .cnt_i          (cnt_s2),
    .sum_i          (sum_s2),
    .and_i          (and_s2),
    .or_i           (or_s2),
    .xor_i          (xor_s2),
    .centre_alive_i (calive_s2_r),
    .centre_wave_i  (cw_s2_r),
    .alive_o        (alive_s3),
    .wave_o         (wave_s3)
  );

  always_ff @(posedge clk) begin
    if (rdy2) begin
      pass_s3_r <= pass_s2_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_data_r.next_alive      <= alive_s3;
      out_data_r.next_wave       <= WAVE_FIELD_W'(wave_s3);
      out_data_r.genome_out      <= pass_s3_r.genome;
      out_data_r.link_genome_out <= pass_s3_r.link;
      out_data_r.fitness_out     <= pass_s3_r.fitness;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input is refused only when every stage holds an item behind a stalled result
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_valid_r && out_stall))
    else $error("input stalled with a free stage");

  // an accepted transfer occupies the first stage
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted item lost at the lane stage");

  // a finished item reaches the output when the output can move
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy3) |=> out_valid_r)
    else $error("item lost between rule stage and output");

endmodule

/* test/ca_cell_rule_update_core_tb.sv */
`timescale 1ns / 100ps

module ca_cell_rule_update_core_tb;
  import cacru_pkg::*;

  localparam int N_DIR        = 24;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 172;
  localparam int PIPE_DEPTH   = 4;
  localparam int HOLD_CYCLES  = 80;
  localparam int WDOG_LIMIT   = 2000;
  localparam logic [WAVE_FIELD_W-1:0]   WAVE_ONES   = WAVE_FIELD_W'((1 << WAVE_BITS_DEF) - 1);
  localparam logic [GENOME_FIELD_W-1:0] GENOME_MASK =
    GENOME_FIELD_W'((1 << GENOME_BITS_DEF) - 1);
  localparam logic [CFG_ADDR_W-1:0]     RULE_ADDR   = {REG_RULE, 2'b00};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // scoreboard and run state
  out_item_t pending_cells[$];
  rule_t rule_cfg = RULE_LIFE;
  int send_pct = 0;
  int recv_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int idle_cnt = 0;
  int fail_cnt = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_settings = 0;

  typedef struct {
    rule_t     rule;
    in_item_t  item;
    bit        has_want;
    out_item_t want;
  } dir_row_t;

  // directed neighbourhoods; expected result typed only where obvious
  dir_row_t dir_tab [N_DIR] = '{
    '{RULE_LIFE, '{9'h000, 8'h00, 64'h0, 8'h00, 64'h0, 32'h0, 32'h0},
      1'b1, '{1'b0, 8'h00, 8'h00, 32'h0, 32'h0}},
    '{RULE_LIFE, '{9'h1FF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF,
      64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      1'b1, '{1'b0, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    '{RULE_LIFE, '{9'h007, 8'h5A, 64'h0123_4567_89AB_CDEF, 8'h3C, 64'h0,
      32'hA5A5_A5A5, 32'h1234_5678}, 1'b0, '0},
    '{RULE_LIFE, '{9'h013, 8'h81, 64'h1111_2222_3333_4444, 8'hC3, 64'h0,
      32'h5A5A_5A5A, 32'h0}, 1'b0, '0},
    '{RULE_LIFE, '{9'h01F, 8'h18, 64'h0, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF,
      32'h0, 32'h8000_0001}, 1'b0, '0},
    '{RULE_DIFFUSE, '{9'h010, 8'h77, 64'hFFFF_FFFF_FFFF_FFFF, 8'h01, 64'h0,
      32'h0, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 8'h77, 8'h01, 32'h0, 32'hFFFF_FFFF}},
    '{RULE_DIFFUSE, '{9'h00F, 8'h00, 64'h0000_0000_4030_2010, 8'h22, 64'h0,
      32'h1, 32'h2}, 1'b0, '0},
    '{RULE_DIFFUSE, '{9'h1E1, 8'h90, 64'hFFFE_FDFC_0000_00FB, 8'h33, 64'h0,
      32'h3, 32'h4}, 1'b0, '0},
    '{RULE_DIFFUSE, '{9'h100, 8'h12, 64'hC700_0000_0000_0000, 8'h44, 64'h0,
      32'h5, 32'h6}, 1'b0, '0},
    '{RULE_GENOMIC, '{9'h00F, 8'h42, 64'h0F1E_2D3C_4B5A_6978, 8'h9C,
      64'h9C9C_9C9C_9C9C_9C9C, 32'h7, 32'h8}, 1'b0, '0},
    '{RULE_GENOMIC, '{9'h003, 8'h43, 64'h0, 8'h00, 64'h0101_0101_0101_0101,
      32'h9, 32'hA}, 1'b0, '0},
    '{RULE_GENOMIC, '{9'h007, 8'h44, 64'h0, 8'h55, 64'h0000_0000_0000_0055,
      32'hB, 32'hC}, 1'b0, '0},
    '{RULE_GENOMIC, '{9'h017, 8'h45, 64'h0, 8'hAA, 64'h00AA_AAAA_AAAA_AAAA,
      32'hD, 32'hE}, 1'b0, '0},
    '{RULE_AND, '{9'h000, 8'hC3, 64'hFFFF_FFFF_FFFF_FFFF, 8'h11, 64'h0,
      32'h0, 32'h0}, 1'b1, '{1'b0, 8'hC3, 8'h11, 32'h0, 32'h0}},
    '{RULE_AND, '{9'h1EF, 8'hFF, 64'hF7FB_FDFE_7FBF_DFEF, 8'h66, 64'h0,
      32'h10, 32'h20}, 1'b0, '0},
    '{RULE_OR, '{9'h0A5, 8'h00, 64'h8040_2010_0804_0201, 8'h77, 64'h0,
      32'h30, 32'h40}, 1'b0, '0},
    '{RULE_XOR, '{9'h1FF, 8'hFF, 64'hFF00_FF00_1234_5678, 8'h88, 64'h0,
      32'h50, 32'h60}, 1'b0, '0},
    '{RULE_THR_AND, '{9'h010, 8'hE0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 64'h0,
      32'h0F0F_0F0F, 32'h0}, 1'b1, '{1'b0, 8'hE0, 8'hFF, 32'h0F0F_0F0F, 32'h0}},
    '{RULE_THR_AND, '{9'h003, 8'h05, 64'h0000_0000_0000_817F, 8'h99, 64'h0,
      32'h70, 32'h80}, 1'b0, '0},
    '{RULE_THR_AND, '{9'h003, 8'h06, 64'h0000_0000_0000_7F7F, 8'h9A, 64'h0,
      32'h90, 32'hA0}, 1'b0, '0},
    '{RULE_THR_OR, '{9'h010, 8'hBF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hBB, 64'h0,
      32'hB0, 32'hC0}, 1'b0, '0},
    '{RULE_THR_OR, '{9'h000, 8'hC0, 64'h0, 8'hCC, 64'h0,
      32'hD0, 32'hE0}, 1'b0, '0},
    '{RULE_THR_OR, '{9'h020, 8'h00, 64'h0, 8'hDD, 64'h0,
      32'hF0, 32'hF1}, 1'b0, '0},
    '{RULE_LIFE, '{9'h1EF, 8'h3F, 64'h0, 8'hEE, 64'h0,
      32'hF2, 32'hF3}, 1'b0, '0}
  };

  ca_cell_rule_update_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // next cell state under the given rule
  function automatic out_item_t predict_next_cell(input in_item_t c, input rule_t rule);
    out_item_t r;
    logic [WAVE_FIELD_W-1:0] cw, w, v_and, v_or, v_xor, wave;
    logic [GENOME_FIELD_W-1:0] cg;
    int unsigned n, m, total, avg, birth;
    int k, cell_idx;
    logic centre, alive;
    cw     = c.center_wave & WAVE_ONES;
    cg     = c.center_genome & GENOME_MASK;
    centre = c.alive_mask[CENTRE_CELL];
    n = 0;
    m = 0;
    total = 0;
    v_and = cw;
    v_or  = cw;
    v_xor = cw;
    // gather the eight neighbours
    for (k = 0; k < NUM_LANES; k++) begin
      cell_idx = (k < CENTRE_CELL) ? k : k + 1;
      w = c.neighbor_waves[8*k +: 8] & WAVE_ONES;
      if ((c.neighbor_genomes[8*k +: 8] & GENOME_MASK) == cg) m++;
      if (c.alive_mask[cell_idx]) begin
        n++;
        total += w;
        v_and &= w;
        v_or  |= w;
        v_xor ^= w;
      end
    end
    avg   = (n != 0) ? total / n : 0;
    alive = 1'b0;
    wave  = cw;
    case (rule)
      RULE_LIFE: alive = centre ? (n == 2 || n == 3) : (n == 3);
      RULE_DIFFUSE: begin
        alive = (n >= 2 && n <= 4);
        if (n != 0) wave = WAVE_FIELD_W'(avg);
      end
      RULE_GENOMIC: begin
        birth = (m >= 7) ? 4 : ((m <= 1) ? 2 : 3);
        alive = centre ? (n == 2 || n == 3) : (n == birth);
      end
      RULE_AND: begin
        alive = (n > 0);
        wave  = v_and;
      end
      RULE_OR: begin
        alive = (n > 0);
        wave  = v_or;
      end
      RULE_XOR: begin
        alive = (n > 0);
        wave  = v_xor;
      end
      RULE_THR_AND: begin
        alive = (n >= 2) && (avg > (int'(WAVE_ONES) >> 1));
        if (alive) wave = WAVE_FIELD_W'(avg);
      end
      default: alive = (n > 0) || (int'(cw) > ((int'(WAVE_ONES) * 3) >> 2));
    endcase
    r.next_alive      = alive;
    r.next_wave       = wave & WAVE_ONES;
    r.genome_out      = cg;
    r.link_genome_out = c.center_link_genome;
    r.fitness_out     = c.center_fitness;
    return r;
  endfunction

  // random neighbourhood, biased towards interesting counts and matches
  function automatic in_item_t rand_cell();
    in_item_t c;
    int want_n, got, lane, k, wmode, match_pct;
    logic [7:0] b;
    c.center_link_genome = $urandom();
    c.center_fitness     = $urandom();
    c.center_genome      = 8'($urandom_range(255));
    // alive mask: raw, or a chosen number of alive neighbours
    if ($urandom_range(1) == 0) begin
      c.alive_mask = 9'($urandom_range(511));
    end else begin
      c.alive_mask = '0;
      c.alive_mask[CENTRE_CELL] = 1'($urandom_range(1));
      want_n = $urandom_range(NUM_LANES);
      got = 0;
      while (got < want_n) begin
        lane = $urandom_range(NUM_LANES - 1);
        if (lane >= CENTRE_CELL) lane++;
        if (!c.alive_mask[lane]) begin
          c.alive_mask[lane] = 1'b1;
          got++;
        end
      end
    end
    // neighbour waves: full range, high, low or extremes
    wmode = $urandom_range(3);
    for (k = 0; k < NUM_LANES; k++) begin
      case (wmode)
        0:       b = 8'($urandom_range(255));
        1:       b = 8'($urandom_range(255, 96));
        2:       b = 8'($urandom_range(127));
        default: b = $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
      c.neighbor_waves[8*k +: 8] = b;
    end
    // centre wave, often near the threshold-or boundary
    case ($urandom_range(3))
      1:       c.center_wave = 8'($urandom_range(200, 182));
      2:       c.center_wave = $urandom_range(1) ? 8'hFF : 8'h00;
      default: c.center_wave = 8'($urandom_range(255));
    endcase
    // neighbour genomes with a chosen share matching the centre
    case ($urandom_range(4))
      0:       match_pct = 0;
      1:       match_pct = 15;
      2:       match_pct = 50;
      3:       match_pct = 85;
      default: match_pct = 100;
    endcase
    for (k = 0; k < NUM_LANES; k++) begin
      if ($urandom_range(99) < match_pct) c.neighbor_genomes[8*k +: 8] = c.center_genome;
      else c.neighbor_genomes[8*k +: 8] = 8'($urandom_range(255));
    end
    return c;
  endfunction

  // one input transfer, with random idle cycles in front
  task automatic offer_cell(input in_item_t c, input out_item_t want);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall);
    pending_cells.push_back(want);
    n_sent++;
  endtask

  // stop sending and wait for every pending result
  task automatic drain_pending();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // write the rule register, then read it back
  task automatic set_rule(input rule_t r);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= RULE_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(r);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rule_cfg = r;
    n_settings++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[RULE_W-1:0] !== r) begin
      $error("rule_select: expected %0d, got %0d", r, cfg_prdata[RULE_W-1:0]);
      fail_cnt++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // result check, receiver stalls and watchdog
  always @(posedge clk) begin : result_side
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cells.size() == 0) begin
        $error("result transfer with nothing pending");
        fail_cnt++;
      end else begin
        want = pending_cells.pop_front();
        n_checked++;
        if (out_data.next_alive !== want.next_alive) begin
          $error("next_alive: expected %0d, got %0d", want.next_alive, out_data.next_alive);
          fail_cnt++;
        end
        if (out_data.next_wave !== want.next_wave) begin
          $error("next_wave: expected %0h, got %0h", want.next_wave, out_data.next_wave);
          fail_cnt++;
        end
        if (out_data.genome_out !== want.genome_out) begin
          $error("genome_out: expected %0h, got %0h", want.genome_out, out_data.genome_out);
          fail_cnt++;
        end
        if (out_data.link_genome_out !== want.link_genome_out) begin
          $error("link_genome_out: expected %0h, got %0h",
                 want.link_genome_out, out_data.link_genome_out);
          fail_cnt++;
        end
        if (out_data.fitness_out !== want.fitness_out) begin
          $error("fitness_out: expected %0h, got %0h", want.fitness_out, out_data.fitness_out);
          fail_cnt++;
        end
      end
    end

    // receiver: one long hold when asked, otherwise random stalls
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end

    // watchdog on cycles without any transfer
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cnt++;
    else idle_cnt = 0;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t c;
    int p, i, first_rule;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].rule != rule_cfg) begin
        drain_pending();
        set_rule(dir_tab[i].rule);
      end
      offer_cell(dir_tab[i].item, dir_tab[i].has_want ? dir_tab[i].want
                                    : predict_next_cell(dir_tab[i].item, rule_cfg));
    end

    // random phases, one per rule, cycling through the idle patterns
    first_rule = $urandom_range(7);
    for (p = 0; p < N_PHASES; p++) begin
      drain_pending();
      set_rule(rule_t'((first_rule + 3 * p) % 8));
      case (p % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 53; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 53; end
        default: begin send_pct = 16; recv_pct = 16; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // back-pressure: receiver holds off while the sender keeps going
        if (p == 0 && i == 40) hold_req = 1'b1;
        c = rand_cell();
        offer_cell(c, predict_next_cell(c, rule_cfg));
      end
    end

    drain_pending();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    $display("covered %0d neighbourhoods under %0d rule settings, %0d results checked",
             n_sent, n_settings, n_checked);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
